// File: hdl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher: command codes,
// wildcard characters and the structs passed between the matcher cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

   localparam int CMD_WIDTH  = 2;
   localparam int CHAR_WIDTH = 8;

   // command codes of an input transfer
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_TEXT   = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_END    = 2'd3;

   // wildcard characters
   localparam logic [CHAR_WIDTH-1:0] CHAR_ANY_ONE = 8'h3F;  // '?'
   localparam logic [CHAR_WIDTH-1:0] CHAR_ANY_RUN = 8'h2A;  // '*'

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                  restart;  // reseed the active set at position zero
      logic                  consume;  // step the active set over one text byte
      logic                  clear;    // drop the stored pattern
      logic                  append;   // store ch at the first free cell
      logic [CHAR_WIDTH-1:0] ch;
   } wgm_ctl_type;

   // activity handed from one cell to its right neighbor
   typedef struct packed {
      logic adv;    // left position matched the text byte
      logic carry;  // left position is active and holds a star
   } wgm_link_type;

endpackage

// File: hdl/wgm_req_if.sv
// ----------------------------------------------------------------------------
// wgm_req_if
// Request channel of the glob matcher: command and byte with valid/ready.
// ----------------------------------------------------------------------------
interface wgm_req_if;
   import wgm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_WIDTH-1:0]  cmd;
   logic [CHAR_WIDTH-1:0] ch;

   modport source (output valid, output cmd, output ch, input ready);
   modport sink   (input valid, input cmd, input ch, output ready);

endinterface

// File: hdl/wgm_rsp_if.sv
// ----------------------------------------------------------------------------
// wgm_rsp_if
// Response channel of the glob matcher: match and overflow flags with
// valid/ready.
// ----------------------------------------------------------------------------
interface wgm_rsp_if;

   logic valid;
   logic ready;
   logic matched;
   logic overflow;

   modport source (output valid, output matched, output overflow, input ready);
   modport sink   (input valid, input matched, input overflow, output ready);

endinterface

// File: hdl/wgm_cell.sv
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its pattern byte, a stored flag and the active
// bit of its position, and passes match activity to its right neighbor.
// ----------------------------------------------------------------------------
module wgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wgm_pkg::wgm_ctl_type  ctl,
   input  logic                  left_valid,
   input  wgm_pkg::wgm_link_type link_in,
   output wgm_pkg::wgm_link_type link_out,
   output logic                  valid_out,
   output logic                  hit
);
   import wgm_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [CHAR_WIDTH-1:0] byte_ff;
   logic [CHAR_WIDTH-1:0] byte_in;
   logic                  act_ff;
   logic                  act_in;
   logic                  load;
   logic                  is_star;
   logic                  is_one;
   logic                  is_equal;
   logic                  stay;
   logic                  closed;

   // this cell is the first free one when its left neighbor is stored
   assign load = ctl.append && left_valid && !valid_ff;

   // pattern store of this position
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (load) begin
         valid_in = 1'b1;
         byte_in  = ctl.ch;
      end
   end

   // byte classes, taken on the pattern as it stands after this transfer
   assign is_star  = (byte_in == CHAR_ANY_RUN);
   assign is_one   = (byte_in == CHAR_ANY_ONE);
   assign is_equal = (byte_in == ctl.ch);

   // a star keeps its own position alive on any text byte
   assign stay   = ctl.consume && act_ff && valid_in && is_star;
   assign closed = stay || link_in.adv || link_in.carry;

   // activity handed to the next position
   assign link_out.adv   = ctl.consume && act_ff && valid_in && !is_star
                           && (is_one || is_equal);
   assign link_out.carry = closed && valid_in && is_star;

   // active bit follows a restart or a text byte, otherwise holds
   assign act_in = (ctl.restart || ctl.consume) ? closed : act_ff;

   // reset drives ctl.restart and ctl.clear, so act_in is the reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         act_ff   <= act_in;
      end else begin
         valid_ff <= valid_in;
         act_ff   <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // this position is the end of the stored pattern
   assign hit       = act_ff && !valid_ff && left_valid;
   assign valid_out = valid_ff;

endmodule

// File: hdl/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Whole-string glob matcher over a byte stream with a loadable pattern.
// ----------------------------------------------------------------------------
// A new request transfer is taken in each cycle while the response register
// is free or being drained, so one pattern or text byte goes through per
// clock. The pattern lives in a row of MAX_PATTERN cells, each holding one
// byte and the active bit of its position; a text byte moves activity one
// cell to the right and stars pass it on through the row in the same cycle,
// so the clock period is set by a ripple across all cells, much like a carry
// chain of MAX_PATTERN bits. Commands: clear, append a pattern byte, text
// byte, and end of text, which returns one response (matched, overflow) and
// restarts matching. '?' matches one byte, '*' any run including an empty
// one; appends beyond MAX_PATTERN bytes are dropped and reported as overflow
// with matched low.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic      clock,
   input  logic      reset,
   wgm_req_if.sink   req,
   wgm_rsp_if.source rsp
);
   import wgm_pkg::*;

   logic                 accepted;
   wgm_ctl_type          ctl;
   wgm_link_type         link [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] valid_q;
   logic [MAX_PATTERN-1:0] hit_q;
   logic                 last_ff;
   logic                 last_in;
   logic                 last_closed;
   logic                 ovf_ff;
   logic                 ovf_in;
   logic                 hit;
   logic                 is_clear;
   logic                 is_append;
   logic                 is_text;
   logic                 is_end;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_matched_ff;
   logic                 rsp_overflow_ff;

   // request transfer whenever the response register can take a result
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accepted  = req.valid && req.ready;

   // command decode
   always_comb begin
      is_clear  = 1'b0;
      is_append = 1'b0;
      is_text   = 1'b0;
      is_end    = 1'b0;
      unique case (req.cmd)
         CMD_CLEAR:  is_clear  = 1'b1;
         CMD_APPEND: is_append = 1'b1;
         CMD_TEXT:   is_text   = 1'b1;
         CMD_END:    is_end    = 1'b1;
         default:    is_end    = 1'b0;
      endcase
   end

   // control broadcast; reset acts as clear plus restart
   assign ctl.restart = reset || (accepted && !is_text);
   assign ctl.consume = !reset && accepted && is_text;
   assign ctl.clear   = reset || (accepted && is_clear);
   assign ctl.append  = !reset && accepted && is_append;
   assign ctl.ch      = req.ch;

   // position zero is seeded on every restart
   assign link[0].adv   = 1'b0;
   assign link[0].carry = ctl.restart;

   // row of cells, one per pattern position
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic left_valid;
      if (i == 0) begin : g_first
         assign left_valid = 1'b1;
      end else begin : g_rest
         assign left_valid = valid_q[i-1];
      end
      wgm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_valid (left_valid),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .valid_out  (valid_q[i]),
         .hit        (hit_q[i])
      );
   end

   // active bit of the position past the last cell
   assign last_closed = link[MAX_PATTERN].adv || link[MAX_PATTERN].carry;
   assign last_in     = (ctl.restart || ctl.consume) ? last_closed : last_ff;

   // overflow flag: set by an append into a full row, dropped by clear
   always_comb begin
      ovf_in = ovf_ff;
      if (ctl.clear) begin
         ovf_in = 1'b0;
      end else if (ctl.append && valid_q[MAX_PATTERN-1]) begin
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
         ovf_ff  <= 1'b0;
      end else begin
         last_ff <= last_in;
         ovf_ff  <= ovf_in;
      end
   end

   // active bit at the pattern length
   assign hit = (|hit_q) || (last_ff && valid_q[MAX_PATTERN-1]);

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accepted && is_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accepted && is_end) begin
         rsp_matched_ff  <= hit && !ovf_ff;
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.matched  = rsp_matched_ff;
   assign rsp.overflow = rsp_overflow_ff;

   // stored cells always form a contiguous run from position zero
   assert property (@(posedge clock) disable iff (reset)
      (({1'b0, valid_q} + {{MAX_PATTERN{1'b0}}, 1'b1}) & {1'b0, valid_q}) == '0)
      else $error("pattern cells not contiguous");

   // an end-of-text transfer always yields a pending response
   assert property (@(posedge clock) disable iff (reset)
      accepted && is_end |=> rsp_valid_ff)
      else $error("end of text without response");

   // a clear empties the row and drops overflow
   assert property (@(posedge clock) disable iff (reset)
      accepted && is_clear |=> (valid_q == '0) && !ovf_ff)
      else $error("clear left pattern state behind");

   // an overflowed pattern never reports a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> !rsp_matched_ff)
      else $error("match reported with overflow");

endmodule

// File: sim/wildcard_glob_matcher_test.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_test
// Self-checking bench for the glob matcher. Directed tests cover the empty
// text and pattern, zero and all-ones bytes, trailing stars and a full
// pattern store. Random pattern and text sequences with mostly derived text
// follow. A bit-parallel model of the active pattern positions predicts each
// end-of-text verdict. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wgm_pkg::*;

   localparam int MAX_PAT     = 32;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic matched;
      logic overflow;
   } glob_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wgm_req_if req_if ();
   wgm_rsp_if rsp_if ();

   wildcard_glob_matcher #(
      .MAX_PATTERN(MAX_PAT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   always #1 clock = ~clock;

   // idle rates and counters
   int unsigned send_idle_pct = 18;
   int unsigned recv_idle_pct = 60;
   int unsigned hold_seq      = 0;
   int unsigned err_count     = 0;
   int unsigned items_sent    = 0;
   int unsigned verdicts_seen = 0;
   int unsigned match_count   = 0;
   int unsigned ovf_count     = 0;

   glob_verdict_type verdict_q[$];

   // predictor state: stored pattern and active positions
   logic [CHAR_WIDTH-1:0] glob_pat[MAX_PAT];
   int unsigned           glob_len = 0;
   logic [MAX_PAT:0]      live_pos = {{MAX_PAT{1'b0}}, 1'b1};
   logic                  glob_ovf = 1'b0;

   // activity flows right through stars, which may match nothing
   function automatic void spread_stars();
      for (int i = 0; i < glob_len; i++) begin
         if (live_pos[i] && glob_pat[i] == CHAR_ANY_RUN) live_pos[i+1] = 1'b1;
      end
   endfunction

   function automatic void reseed_positions();
      live_pos    = '0;
      live_pos[0] = 1'b1;
      spread_stars();
   endfunction

   function automatic void step_text_byte(input logic [CHAR_WIDTH-1:0] c);
      logic [MAX_PAT:0] nxt;
      nxt = '0;
      for (int i = 0; i < glob_len; i++) begin
         if (live_pos[i]) begin
            if (glob_pat[i] == CHAR_ANY_RUN) nxt[i] = 1'b1;
            else if (glob_pat[i] == CHAR_ANY_ONE || glob_pat[i] == c) nxt[i+1] = 1'b1;
         end
      end
      live_pos = nxt;
      spread_stars();
   endfunction

   // update the model for one accepted request and queue any verdict
   function automatic void glob_predict(input logic [CMD_WIDTH-1:0] cmd,
                                        input logic [CHAR_WIDTH-1:0] ch);
      glob_verdict_type v;
      case (cmd)
         CMD_CLEAR: begin
            glob_len = 0;
            glob_ovf = 1'b0;
            reseed_positions();
         end
         CMD_APPEND: begin
            if (glob_len < MAX_PAT) begin
               glob_pat[glob_len] = ch;
               glob_len++;
            end else begin
               glob_ovf = 1'b1;
            end
            reseed_positions();
         end
         CMD_TEXT: begin
            step_text_byte(ch);
         end
         default: begin
            v.matched  = live_pos[glob_len] && !glob_ovf;
            v.overflow = glob_ovf;
            verdict_q.push_back(v);
            reseed_positions();
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      err_count++;
   endtask

   // one request transfer, with an optional idle gap in front
   task automatic send_item(input logic [CMD_WIDTH-1:0] cmd,
                            input logic [CHAR_WIDTH-1:0] ch);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= cmd;
      req_if.ch    <= ch;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      glob_predict(cmd, ch);
      items_sent++;
   endtask

   // sender goes quiet until every verdict is back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   function automatic logic [CHAR_WIDTH-1:0] pick_pat_byte();
      case ($urandom_range(9))
         0, 1, 2: return CHAR_ANY_RUN;
         3, 4:    return CHAR_ANY_ONE;
         5:       return "a";
         6:       return "b";
         7:       return 8'h00;
         8:       return 8'hFF;
         default: return CHAR_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] pick_text_byte();
      case ($urandom_range(7))
         0:       return "a";
         1:       return "b";
         2:       return 8'h00;
         3:       return 8'hFF;
         4:       return CHAR_ANY_RUN;
         5:       return CHAR_ANY_ONE;
         default: return CHAR_WIDTH'($urandom);
      endcase
   endfunction

   // receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin : rsp_sink
      static int unsigned hold_seen = 0;
      static int unsigned hold_left = 0;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // verdict checker
   always @(posedge clock) begin
      glob_verdict_type exp_v;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("verdict with none expected");
         end else begin
            exp_v = verdict_q.pop_front();
            verdicts_seen++;
            if (rsp_if.matched !== exp_v.matched)
               report_mismatch($sformatf("matched %b, expected %b",
                                         rsp_if.matched, exp_v.matched));
            if (rsp_if.overflow !== exp_v.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_if.overflow, exp_v.overflow));
            if (exp_v.matched) match_count++;
            if (exp_v.overflow) ovf_count++;
         end
      end
   end

   // empty text against the empty pattern and against a pattern of stars
   task automatic test_empty_text();
      send_item(CMD_END, CHAR_WIDTH'($urandom));
      send_item(CMD_CLEAR, CHAR_WIDTH'($urandom));
      send_item(CMD_APPEND, CHAR_ANY_RUN);
      send_item(CMD_APPEND, CHAR_ANY_RUN);
      send_item(CMD_END, CHAR_WIDTH'($urandom));
   endtask

   // zero and all-ones literals, '?', a star that swallows a run and one
   // that matches nothing at the end
   task automatic test_wildcards();
      send_item(CMD_CLEAR, 8'hFF);
      send_item(CMD_APPEND, 8'h00);
      send_item(CMD_APPEND, CHAR_ANY_ONE);
      send_item(CMD_APPEND, CHAR_ANY_RUN);
      send_item(CMD_APPEND, 8'hFF);
      send_item(CMD_TEXT, 8'h00);
      send_item(CMD_TEXT, 8'h7F);
      send_item(CMD_TEXT, 8'h11);
      send_item(CMD_TEXT, 8'hFF);
      send_item(CMD_END, 8'h00);
      send_item(CMD_TEXT, 8'h00);
      send_item(CMD_TEXT, 8'hFF);
      send_item(CMD_END, 8'h00);
      send_item(CMD_CLEAR, 8'h00);
      send_item(CMD_APPEND, "a");
      send_item(CMD_APPEND, CHAR_ANY_RUN);
      send_item(CMD_TEXT, "a");
      send_item(CMD_END, 8'hFF);
   endtask

   // fill the store, then one append too many, then clear
   task automatic test_store_full();
      send_item(CMD_CLEAR, 8'h00);
      repeat (MAX_PAT) send_item(CMD_APPEND, CHAR_ANY_RUN);
      send_item(CMD_END, 8'h00);
      send_item(CMD_APPEND, "x");
      send_item(CMD_END, 8'h00);
      send_item(CMD_CLEAR, 8'h00);
      send_item(CMD_END, 8'h00);
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      send_item(CMD_CLEAR, 8'h00);
      send_item(CMD_APPEND, "a");
      send_item(CMD_APPEND, CHAR_ANY_RUN);
      hold_seq <= hold_seq + 1;
      for (int k = 0; k < 30; k++) begin
         if (k % 3 == 2) send_item(CMD_END, CHAR_WIDTH'($urandom));
         else send_item(CMD_TEXT, ($urandom_range(1) != 0) ? "a" : pick_text_byte());
      end
      drain_results();
   endtask

   // random pattern and text sequences, with some noise and broken sequences
   task automatic run_random_phase(input int unsigned n_items);
      int unsigned           stop_at;
      int unsigned           pat_len;
      logic [CMD_WIDTH-1:0]  rnd_cmd;
      logic [CHAR_WIDTH-1:0] gen_pat[$];
      logic [CHAR_WIDTH-1:0] txt[$];
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 8) begin
            rnd_cmd = CMD_WIDTH'($urandom_range(3));
            send_item(rnd_cmd, CHAR_WIDTH'($urandom));
         end else begin
            // new pattern, now and then long enough to fill the store
            pat_len = ($urandom_range(15) == 0) ? $urandom_range(28, 36)
                                                : $urandom_range(0, 8);
            gen_pat.delete();
            send_item(CMD_CLEAR, CHAR_WIDTH'($urandom));
            repeat (pat_len) begin
               gen_pat.push_back(pick_pat_byte());
               send_item(CMD_APPEND, gen_pat[$]);
            end
            repeat ($urandom_range(1, 4)) begin
               txt.delete();
               if ($urandom_range(2) == 0) begin
                  repeat ($urandom_range(6)) txt.push_back(pick_text_byte());
               end else begin
                  // text built to fit the pattern, sometimes spoiled
                  foreach (gen_pat[i]) begin
                     if (gen_pat[i] == CHAR_ANY_RUN)
                        repeat ($urandom_range(3)) txt.push_back(pick_text_byte());
                     else if (gen_pat[i] == CHAR_ANY_ONE)
                        txt.push_back(pick_text_byte());
                     else
                        txt.push_back(gen_pat[i]);
                  end
                  if ($urandom_range(3) == 0 && txt.size() != 0)
                     txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
               end
               foreach (txt[i]) begin
                  if ($urandom_range(39) == 0) begin
                     gen_pat.push_back(pick_pat_byte());
                     send_item(CMD_APPEND, gen_pat[$]);
                  end
                  send_item(CMD_TEXT, txt[i]);
               end
               send_item(CMD_END, CHAR_WIDTH'($urandom));
            end
         end
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_CLEAR;
      req_if.ch    = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_text();
      test_wildcards();
      test_store_full();
      test_backpressure();

      send_idle_pct = 18;
      recv_idle_pct = 60;
      run_random_phase(160);
      drain_results();
      send_idle_pct = 60;
      recv_idle_pct = 18;
      run_random_phase(160);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(160);

      drain_results();
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d verdicts: %0d matches, %0d overflows",
               items_sent, verdicts_seen, match_count, ovf_count);
      if (err_count == 0) begin
         $display("wildcard_glob_matcher_test: done, clean");
      end else begin
         $display("%0d mismatches", err_count);
         $display("wildcard_glob_matcher_test: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("timeout with %0d verdicts outstanding", verdict_q.size());
      $display("wildcard_glob_matcher_test: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hdl/wgm_pkg.sv
hdl/wgm_req_if.sv
hdl/wgm_rsp_if.sv
hdl/wgm_cell.sv
hdl/wildcard_glob_matcher.sv
sim/wildcard_glob_matcher_test.sv
